/* sv/ica_pkg.sv */
// ----------------------------------------------------------------------------
// ica_pkg
// types and constants shared by the integer calculator front, queue and back
// ----------------------------------------------------------------------------
package ica_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 6;

	typedef enum logic [2:0] {
		FUNC_ADD  = 3'd0,
		FUNC_SUB  = 3'd1,
		FUNC_MUL  = 3'd2,
		FUNC_DIV  = 3'd3,
		FUNC_POW  = 3'd4,
		FUNC_FACT = 3'd5,
		FUNC_RSV6 = 3'd6,
		FUNC_RSV7 = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_DIVZERO = 2'd1,
		STAT_INVALID = 2'd2
	} stat_t;

	typedef enum logic [3:0] {
		KIND_ADD,
		KIND_SUB,
		KIND_MUL,
		KIND_DIV,
		KIND_POW,
		KIND_FACT,
		KIND_ONE,
		KIND_DIVZERO,
		KIND_INVALID
	} kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_POW,
		BK_FACT
	} bk_state_t;

	typedef struct packed {
		kind_t             kind;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic              neg_q;
		logic              neg_r;
	} item_t;

endpackage

/* sv/ica_front.sv */
// ----------------------------------------------------------------------------
// ica_front
// accepts input beats, classifies the operation and prepares operands
// ----------------------------------------------------------------------------
module ica_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [2:0]                func,
	input  logic [ica_pkg::DATA_W-1:0] operand_a,
	input  logic [ica_pkg::DATA_W-1:0] operand_b,
	output logic                      push_valid,
	input  logic                      push_full,
	output ica_pkg::item_t            push_item
);

	localparam int W = ica_pkg::DATA_W;

	logic            valid_s1;
	ica_pkg::item_t  item_s1;
	ica_pkg::item_t  item_d;
	logic            a_neg;
	logic            b_neg;
	logic            take;

	assign a_neg    = operand_a[W-1];
	assign b_neg    = operand_b[W-1];
	assign in_stall = valid_s1 && push_full;
	assign take     = in_valid && !in_stall;

	always_comb begin
		item_d       = '0;
		item_d.a     = operand_a;
		item_d.b     = operand_b;
		item_d.kind  = ica_pkg::KIND_INVALID;
		unique case (ica_pkg::func_t'(func))
			ica_pkg::FUNC_ADD: item_d.kind = ica_pkg::KIND_ADD;
			ica_pkg::FUNC_SUB: item_d.kind = ica_pkg::KIND_SUB;
			ica_pkg::FUNC_MUL: item_d.kind = ica_pkg::KIND_MUL;
			ica_pkg::FUNC_DIV: begin
				if (operand_b == '0) begin
					item_d.kind = ica_pkg::KIND_DIVZERO;
				end else begin
					item_d.kind  = ica_pkg::KIND_DIV;
					item_d.a     = a_neg ? (~operand_a + W'(1)) : operand_a;
					item_d.b     = b_neg ? (~operand_b + W'(1)) : operand_b;
					item_d.neg_q = a_neg ^ b_neg;
					item_d.neg_r = a_neg;
				end
			end
			ica_pkg::FUNC_POW: begin
				if (b_neg || operand_b == '0) begin
					item_d.kind = ica_pkg::KIND_ONE;
				end else begin
					item_d.kind = ica_pkg::KIND_POW;
				end
			end
			ica_pkg::FUNC_FACT: begin
				if (a_neg || operand_a < W'(2)) begin
					item_d.kind = ica_pkg::KIND_ONE;
				end else begin
					item_d.kind = ica_pkg::KIND_FACT;
				end
			end
			default: item_d.kind = ica_pkg::KIND_INVALID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!push_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

/* sv/ica_queue.sv */
// ----------------------------------------------------------------------------
// ica_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
module ica_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_full,
	input  ica_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_take,
	output ica_pkg::item_t pop_item
);

	ica_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign push_full = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item  = entry_q[rd_ptr_q];
	assign do_push   = push_valid && !push_full;
	assign do_pop    = pop_valid && pop_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* sv/ica_back.sv */
// ----------------------------------------------------------------------------
// ica_back
// executes queued items: ops finished straight from idle, serial divide,
// iterative power and factorial; holds the result in an output register
// ----------------------------------------------------------------------------
module ica_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pop_valid,
	output logic                       pop_take,
	input  ica_pkg::item_t             pop_item,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ica_pkg::DATA_W-1:0] value,
	output logic [ica_pkg::DATA_W-1:0] remainder,
	output logic [1:0]                 status
);

	localparam int W = ica_pkg::DATA_W;
	localparam int C = ica_pkg::CNT_W;

	ica_pkg::bk_state_t state_q;
	ica_pkg::bk_state_t state_d;

	logic [W-1:0] acc_q;
	logic [W-1:0] sq_q;
	logic [W-1:0] arg_q;
	logic [W-1:0] rem_q;
	logic [C-1:0] cnt_q;
	logic         neg_q_q;
	logic         neg_r_q;

	logic         out_valid_q;
	logic [W-1:0] value_q;
	logic [W-1:0] remainder_q;
	logic [1:0]   status_q;

	logic         out_free;
	logic [W-1:0] mul_x;
	logic [W-1:0] mul_y;
	logic [W-1:0] prod1;
	logic [W-1:0] prod2;
	logic [W-1:0] div_sh;
	logic         div_ge;
	logic [W-1:0] div_rem;
	logic [W-1:0] div_quo;
	logic         div_last;
	logic         pow_last;
	logic [W-1:0] pow_acc;
	logic         fact_done;

	logic         wr_out;
	logic [W-1:0] wr_value;
	logic [W-1:0] wr_rem;
	ica_pkg::stat_t wr_stat;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		mul_x = acc_q;
		mul_y = sq_q;
		if (state_q == ica_pkg::BK_IDLE) begin
			mul_x = pop_item.a;
			mul_y = pop_item.b;
		end else if (state_q == ica_pkg::BK_FACT) begin
			mul_y = W'(cnt_q);
		end
	end

	assign prod1 = W'(mul_x * mul_y);
	assign prod2 = W'(sq_q * sq_q);

	assign div_sh   = {rem_q[W-2:0], arg_q[W-1]};
	assign div_ge   = (div_sh >= sq_q);
	assign div_rem  = div_ge ? (div_sh - sq_q) : div_sh;
	assign div_quo  = {arg_q[W-2:0], div_ge};
	assign div_last = (cnt_q == C'(W - 1));

	assign pow_acc  = rem_q[0] ? prod1 : acc_q;
	assign pow_last = (rem_q[W-1:1] == '0);

	assign fact_done = (acc_q == '0) || ({{(W-C){1'b0}}, cnt_q} > arg_q);

	always_comb begin
		state_d  = state_q;
		pop_take = 1'b0;
		wr_out   = 1'b0;
		wr_value = '0;
		wr_rem   = '0;
		wr_stat  = ica_pkg::STAT_OK;
		unique case (state_q)
			ica_pkg::BK_IDLE: begin
				if (pop_valid && out_free) begin
					pop_take = 1'b1;
					unique case (pop_item.kind)
						ica_pkg::KIND_ADD: begin
							wr_out   = 1'b1;
							wr_value = pop_item.a + pop_item.b;
						end
						ica_pkg::KIND_SUB: begin
							wr_out   = 1'b1;
							wr_value = pop_item.a - pop_item.b;
						end
						ica_pkg::KIND_MUL: begin
							wr_out   = 1'b1;
							wr_value = prod1;
						end
						ica_pkg::KIND_ONE: begin
							wr_out   = 1'b1;
							wr_value = W'(1);
						end
						ica_pkg::KIND_DIVZERO: begin
							wr_out  = 1'b1;
							wr_stat = ica_pkg::STAT_DIVZERO;
						end
						ica_pkg::KIND_DIV:  state_d = ica_pkg::BK_DIV;
						ica_pkg::KIND_POW:  state_d = ica_pkg::BK_POW;
						ica_pkg::KIND_FACT: state_d = ica_pkg::BK_FACT;
						default: begin
							wr_out  = 1'b1;
							wr_stat = ica_pkg::STAT_INVALID;
						end
					endcase
				end
			end
			ica_pkg::BK_DIV: begin
				if (div_last) begin
					wr_out   = 1'b1;
					wr_value = neg_q_q ? (~div_quo + W'(1)) : div_quo;
					wr_rem   = neg_r_q ? (~div_rem + W'(1)) : div_rem;
					state_d  = ica_pkg::BK_IDLE;
				end
			end
			ica_pkg::BK_POW: begin
				if (pow_last) begin
					wr_out   = 1'b1;
					wr_value = pow_acc;
					state_d  = ica_pkg::BK_IDLE;
				end
			end
			ica_pkg::BK_FACT: begin
				if (fact_done) begin
					wr_out   = 1'b1;
					wr_value = acc_q;
					state_d  = ica_pkg::BK_IDLE;
				end
			end
			default: state_d = ica_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ica_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_out) begin
			value_q     <= wr_value;
			remainder_q <= wr_rem;
			status_q    <= wr_stat;
		end
		unique case (state_q)
			ica_pkg::BK_IDLE: begin
				neg_q_q <= pop_item.neg_q;
				neg_r_q <= pop_item.neg_r;
				if (pop_item.kind == ica_pkg::KIND_DIV) begin
					arg_q <= pop_item.a;
					sq_q  <= pop_item.b;
					rem_q <= '0;
					cnt_q <= '0;
				end else if (pop_item.kind == ica_pkg::KIND_FACT) begin
					arg_q <= pop_item.a;
					acc_q <= W'(1);
					cnt_q <= C'(2);
				end else begin
					acc_q <= W'(1);
					sq_q  <= pop_item.a;
					rem_q <= pop_item.b;
					cnt_q <= '0;
				end
			end
			ica_pkg::BK_DIV: begin
				rem_q <= div_rem;
				arg_q <= div_quo;
				cnt_q <= cnt_q + C'(1);
			end
			ica_pkg::BK_POW: begin
				acc_q <= pow_acc;
				sq_q  <= prod2;
				rem_q <= {1'b0, rem_q[W-1:1]};
			end
			ica_pkg::BK_FACT: begin
				acc_q <= prod1;
				cnt_q <= cnt_q + C'(1);
			end
			default: cnt_q <= '0;
		endcase
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign remainder = remainder_q;
	assign status    = status_q;

endmodule

/* sv/integer_calculator_alu.sv */
// ----------------------------------------------------------------------------
// integer_calculator_alu
// integer alu with add, sub, mul, divide, power and factorial, 32-bit wrap
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_stall   | func, operand_a, operand_b
//   out     | output    | out_valid/out_stall | value, remainder, status
//
// add, sub, mul and flagged cases are finished straight from idle; divide,
// power and factorial load their operands in idle, then divide yields one
// quotient bit per cycle, power squares the base for each exponent bit and
// factorial multiplies in each factor, then stops once it passes the operand
// or the product wraps to zero; any op starts only when the result register
// is free; each beat passes the front register and a queue entry first
// reset clears all valid flags and puts the back in idle
// out_stall holds the result register; the queue keeps accepting until full
// ----------------------------------------------------------------------------
module integer_calculator_alu (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 func,
	input  logic [ica_pkg::DATA_W-1:0] operand_a,
	input  logic [ica_pkg::DATA_W-1:0] operand_b,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ica_pkg::DATA_W-1:0] value,
	output logic [ica_pkg::DATA_W-1:0] remainder,
	output logic [1:0]                 status
);

	logic           push_valid;
	logic           push_full;
	ica_pkg::item_t push_item;
	logic           pop_valid;
	logic           pop_take;
	ica_pkg::item_t pop_item;

	ica_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_item  (push_item)
	);

	ica_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_take   (pop_take),
		.pop_item   (pop_item)
	);

	ica_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_take  (pop_take),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.remainder (remainder),
		.status    (status)
	);

endmodule

/* tb/sv/integer_calculator_alu_chk.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_calculator_alu_chk
// watches both channels of the calculator, computes the expected value,
// remainder and status of every accepted input beat and compares them in
// order with the output beats
// ----------------------------------------------------------------------------
module integer_calculator_alu_chk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [2:0]                 func,
	input  logic [ica_pkg::DATA_W-1:0] operand_a,
	input  logic [ica_pkg::DATA_W-1:0] operand_b,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [ica_pkg::DATA_W-1:0] value,
	input  logic [ica_pkg::DATA_W-1:0] remainder,
	input  logic [1:0]                 status,
	output int                         errors,
	output int                         pending
);

	localparam int W = ica_pkg::DATA_W;

	typedef struct packed {
		logic [W-1:0]   val;
		logic [W-1:0]   rem;
		ica_pkg::stat_t st;
	} calc_res_t;

	calc_res_t want_q[$];

	function automatic calc_res_t calc(logic [2:0] f, logic [W-1:0] a,
			logic [W-1:0] b);
		calc_res_t r;
		logic [W-1:0] ma, mb, q, rm, acc, sq, e;
		r.val = '0;
		r.rem = '0;
		r.st  = ica_pkg::STAT_OK;
		case (ica_pkg::func_t'(f))
			ica_pkg::FUNC_ADD: r.val = a + b;
			ica_pkg::FUNC_SUB: r.val = a - b;
			ica_pkg::FUNC_MUL: r.val = a * b;
			ica_pkg::FUNC_DIV: begin
				if (b == 0) begin
					r.st = ica_pkg::STAT_DIVZERO;
				end else begin
					ma = a[W-1] ? -a : a;
					mb = b[W-1] ? -b : b;
					q  = ma / mb;
					rm = ma % mb;
					r.val = (a[W-1] != b[W-1]) ? -q : q;
					r.rem = a[W-1] ? -rm : rm;
				end
			end
			ica_pkg::FUNC_POW: begin
				acc = 1;
				if (!b[W-1]) begin
					sq = a;
					e  = b;
					while (e != 0) begin
						if (e[0])
							acc = acc * sq;
						sq = sq * sq;
						e  = e >> 1;
					end
				end
				r.val = acc;
			end
			ica_pkg::FUNC_FACT: begin
				acc = 1;
				if (!a[W-1]) begin
					for (longint k = 2; k <= a && acc != 0; k++)
						acc = acc * W'(k);
				end
				r.val = acc;
			end
			default: r.st = ica_pkg::STAT_INVALID;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		calc_res_t w;
		if (!arst_n) begin
			errors  <= 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				want_q.push_back(calc(func, operand_a, operand_b));
			if (out_valid && !out_stall) begin
				if (want_q.size() == 0) begin
					$display("%0t: unexpected beat value %h rem %h status %0d",
						$time, value, remainder, status);
					errors <= errors + 1;
				end else begin
					w = want_q.pop_front();
					if (value !== w.val || remainder !== w.rem || status !== w.st) begin
						$display("%0t: mismatch expected %h/%h/%0d actual %h/%h/%0d",
							$time, w.val, w.rem, w.st, value, remainder, status);
						errors <= errors + 1;
					end
				end
			end
			pending <= want_q.size();
		end
	end
endmodule

/* tb/sv/integer_calculator_alu_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_calculator_alu_tb
// drives directed and random operations with random gaps and stalls,
// including a long output hold-off, and reports the checker's verdict
// ----------------------------------------------------------------------------
module integer_calculator_alu_tb;

	localparam int W = ica_pkg::DATA_W;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         in_valid = 0;
	logic         in_stall;
	logic [2:0]   func = 0;
	logic [W-1:0] operand_a = 0;
	logic [W-1:0] operand_b = 0;
	logic         out_valid;
	logic         out_stall = 0;
	logic [W-1:0] value;
	logic [W-1:0] remainder;
	logic [1:0]   status;
	int           errors;
	int           pending;
	int           send_idle = 0;
	int           recv_idle = 0;
	int           holdoff = 0;
	longint       cycles = 0;

	always #1 clk = ~clk;

	integer_calculator_alu dut (.*);
	integer_calculator_alu_chk chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1000000) begin
			$display("[integer_calculator_alu] ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (holdoff > 0) begin
			holdoff   <= holdoff - 1;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	function automatic logic [W-1:0] rand_operand();
		case ($urandom_range(5))
			0: return W'($urandom_range(12));
			1: return W'(-$urandom_range(12));
			2: return W'($urandom_range(40));
			3: return {1'b1, {(W-1){1'b0}}} + W'($urandom_range(1));
			default: return W'($urandom);
		endcase
	endfunction

	task automatic send(logic [2:0] f, logic [W-1:0] a, logic [W-1:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid  <= 1;
		func      <= f;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random(int n);
		logic [2:0] f;
		for (int i = 0; i < n; i++) begin
			f = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
			send(f, rand_operand(), rand_operand());
		end
	endtask

	localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send(ica_pkg::FUNC_ADD, MAX_V, 1);
		send(ica_pkg::FUNC_ADD, '1, '1);
		send(ica_pkg::FUNC_SUB, MIN_V, 1);
		send(ica_pkg::FUNC_SUB, 0, MIN_V);
		send(ica_pkg::FUNC_MUL, MAX_V, MAX_V);
		send(ica_pkg::FUNC_MUL, MIN_V, '1);
		send(ica_pkg::FUNC_DIV, 7, -2);
		send(ica_pkg::FUNC_DIV, -7, 2);
		send(ica_pkg::FUNC_DIV, MIN_V, '1);
		send(ica_pkg::FUNC_DIV, 5, 0);
		send(ica_pkg::FUNC_DIV, MIN_V, MIN_V);
		send(ica_pkg::FUNC_DIV, MAX_V, 1);
		send(ica_pkg::FUNC_POW, 3, 0);
		send(ica_pkg::FUNC_POW, 3, -5);
		send(ica_pkg::FUNC_POW, 3, MAX_V);
		send(ica_pkg::FUNC_POW, -2, 31);
		send(ica_pkg::FUNC_FACT, 1, 0);
		send(ica_pkg::FUNC_FACT, MIN_V, 0);
		send(ica_pkg::FUNC_FACT, 12, 0);
		send(ica_pkg::FUNC_FACT, 13, '1);
		send(ica_pkg::FUNC_FACT, MAX_V, 0);
		send(ica_pkg::FUNC_RSV6, 1, 1);
		send(ica_pkg::FUNC_RSV7, MAX_V, MIN_V);
		send_idle = 22;
		recv_idle = 51;
		run_random(600);
		send_idle = 51;
		recv_idle = 22;
		run_random(600);
		send_idle = 0;
		recv_idle = 0;
		holdoff   = 400;
		run_random(640);
		in_valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("[integer_calculator_alu] OK");
		else
			$display("[integer_calculator_alu] ERROR");
		$finish;
	end
endmodule

/* files.f */
sv/ica_pkg.sv
sv/ica_front.sv
sv/ica_queue.sv
sv/ica_back.sv
sv/integer_calculator_alu.sv
tb/sv/integer_calculator_alu_chk.sv
tb/sv/integer_calculator_alu_tb.sv
